// ===== rtl/core/sgen_pkg.sv =====
package sgen_pkg;

  // Width of the tone, rate, residue and counter datapath.
  localparam int unsigned DATA_W   = 18;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SINE_W   = 15;

  localparam int unsigned ANGLE_BITS_DEF    = 10;
  localparam int unsigned FRAME_SAMPLES_DEF = 256;

  localparam logic [DATA_W-1:0] TONE_RESET = DATA_W'(440);
  localparam logic [DATA_W-1:0] RATE_RESET = DATA_W'(16000);
  localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(8000);

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE_FREQUENCY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE      = 2'd2;

  // pi/2 in Q30.
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Command from the sequencer to the shared divide step unit.
  typedef struct packed {
    logic              load;
    logic              step;
    logic [DATA_W-1:0] load_rem;
    logic [DATA_W-1:0] load_num;
  } sgen_div_cmd_t;

  // Two Q30 multiplications by x: the next odd power before the factorial divide.
  function automatic longint unsigned sq_step(input longint unsigned t,
                                              input longint unsigned x);
    longint unsigned p;
    p = (t * x) >> 30;
    p = (p * x) >> 30;
    return p;
  endfunction

  // Unsigned Q0.15 sine of pi/2 * k / 2^qbits, evaluated only while building the table.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned qbits);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    x    = (64'(k) * PI_HALF_Q30) >> qbits;
    term = x;
    sum  = x;
    term = sq_step(term, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd20;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd72;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd156;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd272;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd342;
    sum  = (sum >= term) ? sum - term : 64'd0;
    sum  = (sum + 64'd16384) >> 15;
    if (sum > 64'd32767) begin
      sum = 64'd32767;
    end
    return sum[SINE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sine_tone_generator_unit.sv =====
// Sine tone generator. Every input word whose tick bit is 1 produces one
// signed 16-bit sample equal to amplitude * sin(2*pi*n*tone/rate), where n is
// a sample counter that wraps to 0 at the sample rate; words with tick 0 are
// taken and dropped. Each sample goes out with tlast set on the last sample of
// every frame of FRAME_SAMPLES samples. The phase is kept as the residue
// (n*tone) mod rate and turned into an ANGLE_BITS-bit angle by a shared
// restoring divider that retires one bit per cycle; a quarter-wave table and
// one 15x15 multiply finish the sample. The tone and the stored residue are
// each first reduced modulo the rate by the divider when they are not already
// below it (after a rate or tone write). s_tready is low while a tick is
// worked on and rises when its sample is loaded into the output register, so
// a tick is taken only once the one before is through; a full output register
// that is not drained holds a finished sample, and so the next tick, back.
// The next tick can be taken while a finished sample still waits in the
// output register. Configuration writes are always accepted and must be
// made only while the block is idle. A sample rate of 0 acts as 1.
module sine_tone_generator_unit
  import sgen_pkg::*;
#(
  parameter int unsigned ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int unsigned FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream: bit 0 tick, bits 7:1 zero padding.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,
  // Output stream: bits 15:0 sample (signed); tlast marks the frame end.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SAMPLE_W-1:0]    m_tdata,
  output logic                   m_tlast,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);
  localparam int unsigned FP_W  = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
  localparam logic [ANGLE_BITS-2:0] QTR_IDX = {1'b1, {(ANGLE_BITS-2){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TMOD  = 6'b000010,
    S_RMOD  = 6'b000100,
    S_ANGLE = 6'b001000,
    S_ROM   = 6'b010000,
    S_MUL   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Configuration registers.
  logic [DATA_W-1:0] tone_frequency;
  logic [DATA_W-1:0] rate_setting;
  logic [AMP_W-1:0]  amplitude;

  // Phase state.
  logic [DATA_W-1:0] sample_counter;
  logic [DATA_W-1:0] angle_residue;
  logic [FP_W-1:0]   frame_position;

  // Working registers for the current tick.
  logic [DATA_W-1:0]         tone_mod, tone_mod_next;
  logic [DATA_W-1:0]         res_mod, res_mod_next;
  logic                      neg;
  logic [2*SINE_W-1:0]       prod;
  logic [SAMPLE_W-1:0]       out_sample;
  logic                      out_last;
  logic                      out_valid;

  sgen_div_cmd_t     cmd;
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] div_num;
  logic [SINE_W-1:0] rom_data;

  logic                  go_res;
  logic                  finish;
  logic [DATA_W-1:0]     rate_eff;
  logic                  tone_small;
  logic                  res_small;
  logic [ANGLE_BITS-1:0] angle;
  logic [ANGLE_BITS-2:0] rom_addr;

  // A rate of zero behaves as one. The user keeps configuration stable while
  // busy (the block does not enforce it), so the rate is used from its register.
  assign rate_eff   = (rate_setting == '0) ? DATA_W'(1) : rate_setting;
  assign tone_small = tone_frequency < rate_eff;
  assign res_small  = angle_residue < rate_eff;

  // Quadrant folding of the angle onto the quarter-wave table.
  assign angle    = div_num[ANGLE_BITS-1:0];
  assign rom_addr = angle[ANGLE_BITS-2] ?
                    (QTR_IDX - {1'b0, angle[ANGLE_BITS-3:0]}) :
                    {1'b0, angle[ANGLE_BITS-3:0]};

  sgen_div_unit u_div (
    .clk     (clk),
    .cmd     (cmd),
    .divisor (rate_eff),
    .rem     (div_rem),
    .num     (div_num)
  );

  sgen_sine_rom #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // Sequencer: reduce the tone and the residue where they are not below the rate,
  // divide the residue into an angle, read the table, scale by the amplitude.
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    tone_mod_next = tone_mod;
    res_mod_next  = res_mod;
    cmd           = '0;
    go_res        = 1'b0;
    finish        = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tdata[0]) begin
          if (tone_small) begin
            tone_mod_next = tone_frequency;
            go_res        = 1'b1;
          end else begin
            cmd.load     = 1'b1;
            cmd.load_rem = '0;
            cmd.load_num = tone_frequency;
            state_next   = S_TMOD;
            cnt_next     = '0;
          end
        end
      end
      S_TMOD: begin
        if (cnt == CNT_W'(DATA_W)) begin
          tone_mod_next = div_rem;
          go_res        = 1'b1;
        end else begin
          cmd.step = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      S_RMOD: begin
        if (cnt == CNT_W'(DATA_W)) begin
          res_mod_next = div_rem;
          cmd.load     = 1'b1;
          cmd.load_rem = div_rem;
          cmd.load_num = '0;
          state_next   = S_ANGLE;
          cnt_next     = '0;
        end else begin
          cmd.step = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      S_ANGLE: begin
        if (cnt == CNT_W'(ANGLE_BITS)) begin
          state_next = S_ROM;
        end else begin
          cmd.step = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROM: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        if (!out_valid || m_tready) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Residue reduction is skipped when it is already below the rate.
    if (go_res) begin
      cnt_next = '0;
      cmd.load = 1'b1;
      if (res_small) begin
        res_mod_next = angle_residue;
        cmd.load_rem = angle_residue;
        cmd.load_num = '0;
        state_next   = S_ANGLE;
      end else begin
        cmd.load_rem = '0;
        cmd.load_num = angle_residue;
        state_next   = S_RMOD;
      end
    end
  end

  // Next phase: counter step, residue advanced by the tone and folded once.
  logic [DATA_W:0]   cnt_inc;
  logic              cnt_wrap;
  logic [DATA_W:0]   res_sum;
  logic [DATA_W:0]   res_sub;
  logic [DATA_W-1:0] res_upd;
  logic [AMP_W-1:0]  mag;
  logic [SAMPLE_W-1:0] sample_val;
  logic              frame_end;

  assign cnt_inc   = {1'b0, sample_counter} + 1'b1;
  assign cnt_wrap  = cnt_inc >= {1'b0, rate_eff};
  assign res_sum   = {1'b0, res_mod} + {1'b0, tone_mod};
  assign res_sub   = res_sum - {1'b0, rate_eff};
  assign res_upd   = (res_sum >= {1'b0, rate_eff}) ? res_sub[DATA_W-1:0] :
                     res_sum[DATA_W-1:0];
  // The product of two Q15 magnitudes stays below 2^30, so no clamp is needed.
  assign mag        = prod[2*SINE_W-1:SINE_W];
  assign sample_val = neg ? (SAMPLE_W'(0) - {1'b0, mag}) : {1'b0, mag};
  assign frame_end  = frame_position == FP_W'(FRAME_SAMPLES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      tone_frequency <= TONE_RESET;
      rate_setting   <= RATE_RESET;
      amplitude      <= AMP_RESET;
      sample_counter <= '0;
      angle_residue  <= '0;
      frame_position <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_TONE_FREQUENCY: tone_frequency <= cfg_data;
          REG_SAMPLE_RATE:    rate_setting   <= cfg_data;
          REG_AMPLITUDE:      amplitude      <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      // A new sample may replace the one leaving in the same cycle.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        frame_position <= frame_end ? '0 : frame_position + 1'b1;
        if (cnt_wrap) begin
          sample_counter <= '0;
          angle_residue  <= '0;
        end else begin
          sample_counter <= cnt_inc[DATA_W-1:0];
          angle_residue  <= res_upd;
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    tone_mod <= tone_mod_next;
    res_mod  <= res_mod_next;
    if (state == S_ANGLE) begin
      neg <= angle[ANGLE_BITS-1];
    end
    if (state == S_ROM) begin
      prod <= (2*SINE_W)'(amplitude) * (2*SINE_W)'(rom_data);
    end
    if (finish) begin
      out_sample <= sample_val;
      out_last   <= frame_end;
    end
  end

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_sample;
  assign m_tlast   = out_last;

endmodule

// ===== rtl/core/sgen_div_unit.sv =====
module sgen_div_unit
  import sgen_pkg::*;
(
  input  logic                clk,
  input  sgen_div_cmd_t       cmd,
  input  logic [DATA_W-1:0]   divisor,
  output logic [DATA_W-1:0]   rem,
  output logic [DATA_W-1:0]   num
);

  // One restoring division step per cycle while a step is commanded. The dividend
  // shifts out of the top of num while quotient bits shift in at the bottom.
  logic [DATA_W:0]   trial;
  logic              fits;
  logic [DATA_W:0]   diff;

  assign trial = {rem, num[DATA_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= cmd.load_rem;
      num <= cmd.load_num;
    end else if (cmd.step) begin
      rem <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      num <= {num[DATA_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/sgen_sine_rom.sv =====
module sgen_sine_rom
  import sgen_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [ANGLE_BITS-2:0] addr,
  output logic [SINE_W-1:0]     data
);

  localparam int unsigned QUARTER = 1 << (ANGLE_BITS - 2);

  // Quarter wave including the peak entry, built at elaboration.
  logic [SINE_W-1:0] sine_tab [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    localparam logic [SINE_W-1:0] VALUE = quarter_sine(k, ANGLE_BITS - 2);
    assign sine_tab[k] = VALUE;
  end

  always_ff @(posedge clk) begin
    data <= sine_tab[addr];
  end

endmodule
